// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define OWB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("owb checker: same-cycle property failed");

// The antecedent implies the consequent in the following cycle.
`define OWB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("owb checker: next-cycle property failed");

`endif

// ===== hw/rtl/owb_pkg.sv =====
// Types and constants of the 1-Wire bus master.
package owb_pkg;

  localparam int unsigned TIME_BITS = 10;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [CFG_W-1:0]     cfg_val_t;

  // Fixed released durations after a slot's low phase.
  localparam time_t HIGH_AFTER_ONE  = time_t'(55);
  localparam time_t HIGH_AFTER_ZERO = time_t'(5);
  localparam time_t READ_TAIL       = time_t'(55);

  // A register value that does not fit the timer saturates at its largest count.
  function automatic time_t sat_time(cfg_val_t v);
    if ((CFG_W > TIME_BITS) && ((v >> TIME_BITS) != '0)) begin
      return '1;
    end
    return time_t'(v);
  endfunction

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETTLE       = 3'd0,
    REG_RESET_LOW    = 3'd1,
    REG_PRES_SAMPLE  = 3'd2,
    REG_RESET_TAIL   = 3'd3,
    REG_WRITE1_LOW   = 3'd4,
    REG_WRITE0_LOW   = 3'd5,
    REG_READ_LOW     = 3'd6,
    REG_READ_SAMPLE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_SETTLE   = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_RST_WAIT = 4'd3,
    PH_RST_TAIL = 4'd4,
    PH_W_LOW    = 4'd5,
    PH_W_HIGH   = 4'd6,
    PH_R_LOW    = 4'd7,
    PH_R_WAIT   = 4'd8,
    PH_R_TAIL   = 4'd9
  } phase_e;

  typedef struct packed {
    time_t settle;
    time_t reset_low;
    time_t pres_sample;
    time_t reset_tail;
    time_t write1_low;
    time_t write0_low;
    time_t read_low;
    time_t read_sample;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    op_e        kind;
    time_t      time_left;
    logic [2:0] bit_idx;
    logic [7:0] shift;
    logic       presence;
    logic [7:0] last_read;
  } owb_state_t;

  // Longest run of end actions one item can cause: settle, reset low,
  // presence wait and reset tail all at zero length.
  localparam int unsigned MAX_CHAIN = 4;

endpackage

// ===== hw/rtl/one_wire_bus_master.sv =====
// Top level of the 1-Wire bus master: input register, phase sequencer, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------------
//  input    | in_valid_i / in_stall_o   | opcode_i, write_data_i, line_level_i
//  result   | out_valid_o / out_stall_i | drive_low_o, busy_res_o, done_res_o,
//           |                           | presence_o, read_data_o, rejected_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Items pass the input, then the result register; one per cycle while out_stall_i is low.
// The sequencer evaluates up to four zero-length phase ends for a single item.
// Reset returns to idle with the default timings and clears presence and read data.
// A stalled result holds the input register, and the input side stalls once that is full.
module one_wire_bus_master
  import owb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           write_data_i,
  input  logic                 line_level_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 drive_low_o,
  output logic                 busy_res_o,
  output logic                 done_res_o,
  output logic                 presence_o,
  output logic [7:0]           read_data_o,
  output logic                 rejected_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  logic       in_valid_q, in_valid_d;
  op_e        op_q;
  logic [7:0] wdata_q;
  logic       line_q;
  logic       accept, fire;

  logic       out_valid_q, out_valid_d;
  logic       drive_low_q, busy_q, done_q, presence_q, rejected_q;
  logic [7:0] read_data_q;

  owb_state_t st_q, st_d;
  logic       done_d, rejected_d;
  logic       drive_low_d, busy_d;
  cfg_t       cfg_q;

  // Handshake between the input register and the result register.
  assign fire        = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~fire;
  assign accept      = in_valid_i & ~in_stall_o;
  assign in_valid_d  = accept | (in_valid_q & ~fire);
  assign out_valid_d = fire | (out_valid_q & out_stall_i);

  function automatic owb_state_t start_slot(owb_state_t s, cfg_t c);
    owb_state_t r;
    r = s;
    if (s.kind == OP_WRITE) begin
      r.phase     = PH_W_LOW;
      r.time_left = s.shift[0] ? c.write1_low : c.write0_low;
    end else begin
      r.phase     = PH_R_LOW;
      r.time_left = c.read_low;
    end
    return r;
  endfunction

  // One phase end action; sets fin when the operation completes.
  function automatic owb_state_t end_phase(owb_state_t s, cfg_t c, logic line,
                                           output logic fin);
    owb_state_t r;
    r   = s;
    fin = 1'b0;
    unique case (s.phase)
      PH_SETTLE: begin
        if (s.kind == OP_RESET) begin
          r.phase     = PH_RST_LOW;
          r.time_left = c.reset_low;
        end else begin
          r = start_slot(s, c);
        end
      end
      PH_RST_LOW: begin
        r.phase     = PH_RST_WAIT;
        r.time_left = c.pres_sample;
      end
      PH_RST_WAIT: begin
        r.presence  = ~line;
        r.phase     = PH_RST_TAIL;
        r.time_left = c.reset_tail;
      end
      PH_W_LOW: begin
        r.phase     = PH_W_HIGH;
        r.time_left = s.shift[0] ? HIGH_AFTER_ONE : HIGH_AFTER_ZERO;
      end
      PH_R_LOW: begin
        r.phase     = PH_R_WAIT;
        r.time_left = c.read_sample;
      end
      PH_R_WAIT: begin
        r.shift     = {line, s.shift[7:1]};
        r.phase     = PH_R_TAIL;
        r.time_left = READ_TAIL;
      end
      PH_W_HIGH, PH_R_TAIL: begin
        if (s.kind == OP_WRITE) begin
          r.shift = {1'b0, s.shift[7:1]};
        end
        if (s.bit_idx == 3'd7) begin
          if (s.kind == OP_READ) begin
            r.last_read = r.shift;
          end
          r.phase     = PH_IDLE;
          r.time_left = '0;
          fin         = 1'b1;
        end else begin
          r.bit_idx = s.bit_idx + 3'd1;
          r = start_slot(r, c);
        end
      end
      default: begin
        r.phase     = PH_IDLE;
        r.time_left = '0;
        fin         = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Next state: apply the item, then run the end actions of phases that expired.
  always_comb begin
    owb_state_t s;
    logic       active;
    logic       fin;
    s          = st_q;
    active     = 1'b0;
    done_d     = 1'b0;
    rejected_d = 1'b0;
    fin        = 1'b0;
    if (op_q == OP_TICK) begin
      if (st_q.phase != PH_IDLE) begin
        if (st_q.time_left != '0) begin
          s.time_left = st_q.time_left - time_t'(1);
        end
        active = 1'b1;
      end
    end else if (st_q.phase != PH_IDLE) begin
      rejected_d = 1'b1;
    end else begin
      s.kind      = op_q;
      s.bit_idx   = '0;
      s.shift     = (op_q == OP_WRITE) ? wdata_q : 8'h00;
      s.phase     = PH_SETTLE;
      s.time_left = cfg_q.settle;
      active      = 1'b1;
    end
    if (active) begin
      for (int i = 0; i < MAX_CHAIN; i++) begin
        if (s.phase != PH_IDLE && s.time_left == '0) begin
          s = end_phase(s, cfg_q, line_q, fin);
          if (fin) begin
            done_d = 1'b1;
          end
        end
      end
    end
    st_d = s;
  end

  // Outputs follow the phase the item leaves behind.
  always_comb begin
    busy_d      = (st_d.phase != PH_IDLE);
    drive_low_d = (st_d.phase == PH_RST_LOW) || (st_d.phase == PH_W_LOW) ||
                  (st_d.phase == PH_R_LOW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{phase: PH_IDLE, kind: OP_TICK, time_left: '0, bit_idx: '0,
                       shift: '0, presence: 1'b0, last_read: '0};
      cfg_q       <= '{settle: sat_time(cfg_val_t'(10)),
                       reset_low: sat_time(cfg_val_t'(520)),
                       pres_sample: sat_time(cfg_val_t'(57)),
                       reset_tail: sat_time(cfg_val_t'(200)),
                       write1_low: sat_time(cfg_val_t'(6)),
                       write0_low: sat_time(cfg_val_t'(60)),
                       read_low: sat_time(cfg_val_t'(2)),
                       read_sample: sat_time(cfg_val_t'(8))};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        st_q <= st_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          REG_SETTLE:      cfg_q.settle      <= sat_time(cfg_wdata_i);
          REG_RESET_LOW:   cfg_q.reset_low   <= sat_time(cfg_wdata_i);
          REG_PRES_SAMPLE: cfg_q.pres_sample <= sat_time(cfg_wdata_i);
          REG_RESET_TAIL:  cfg_q.reset_tail  <= sat_time(cfg_wdata_i);
          REG_WRITE1_LOW:  cfg_q.write1_low  <= sat_time(cfg_wdata_i);
          REG_WRITE0_LOW:  cfg_q.write0_low  <= sat_time(cfg_wdata_i);
          REG_READ_LOW:    cfg_q.read_low    <= sat_time(cfg_wdata_i);
          REG_READ_SAMPLE: cfg_q.read_sample <= sat_time(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  // Payload registers of both stages.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(opcode_i);
      wdata_q <= write_data_i;
      line_q  <= line_level_i;
    end
    if (fire) begin
      drive_low_q <= drive_low_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      presence_q  <= st_d.presence;
      read_data_q <= st_d.last_read;
      rejected_q  <= rejected_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = drive_low_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign presence_o  = presence_q;
  assign read_data_o = read_data_q;
  assign rejected_o  = rejected_q;

endmodule

// ===== hw/rtl/owb_checker.sv =====
// Port-level checker for the 1-Wire bus master, bound to the top level.
`include "assert_macros.svh"

module owb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_low_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] read_data_o,
  input logic       rejected_o
);

  logic stalled;
  assign stalled = out_valid_o & out_stall_i;

  // A stalled result keeps its item.
  `OWB_ASSERT_NXT(a_out_hold, stalled, out_valid_o && $stable(read_data_o) && $stable(busy_res_o))

  // A finished operation leaves the block idle.
  `OWB_ASSERT_IMP(a_done_idle, out_valid_o && done_res_o, !busy_res_o)

  // A command is only dropped while an operation runs, and it leaves that operation running.
  `OWB_ASSERT_IMP(a_reject_busy, out_valid_o && rejected_o, busy_res_o && !done_res_o)

  // The line is only pulled low during an operation.
  `OWB_ASSERT_IMP(a_drive_busy, out_valid_o && drive_low_o, busy_res_o)

endmodule

bind one_wire_bus_master owb_checker u_owb_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking testbench for the 1-Wire bus master: timed stimulus and a cycle-free predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import owb_pkg::*;

  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PATTERN, STALL_HEAVY} stall_mode_e;

  // Predicts the bus master from the items it accepts and checks its results in order.
  class owb_scoreboard;
    cfg_t       cfg;
    phase_e     ph;
    op_e        kind;
    time_t      left;
    logic [2:0] bit_idx;
    logic [7:0] shift;
    logic       pres;
    logic [7:0] last_read;
    logic [12:0] expected_q[$];
    int unsigned errors, items, ops_done, rejects, presences;

    function new();
      cfg = '{settle: sat_time(cfg_val_t'(10)), reset_low: sat_time(cfg_val_t'(520)),
              pres_sample: sat_time(cfg_val_t'(57)), reset_tail: sat_time(cfg_val_t'(200)),
              write1_low: sat_time(cfg_val_t'(6)), write0_low: sat_time(cfg_val_t'(60)),
              read_low: sat_time(cfg_val_t'(2)), read_sample: sat_time(cfg_val_t'(8))};
      ph = PH_IDLE;
      kind = OP_TICK;
      left = '0;
      bit_idx = '0;
      shift = '0;
      pres = 1'b0;
      last_read = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, cfg_val_t v);
      case (idx)
        REG_SETTLE:      cfg.settle = sat_time(v);
        REG_RESET_LOW:   cfg.reset_low = sat_time(v);
        REG_PRES_SAMPLE: cfg.pres_sample = sat_time(v);
        REG_RESET_TAIL:  cfg.reset_tail = sat_time(v);
        REG_WRITE1_LOW:  cfg.write1_low = sat_time(v);
        REG_WRITE0_LOW:  cfg.write0_low = sat_time(v);
        REG_READ_LOW:    cfg.read_low = sat_time(v);
        default:         cfg.read_sample = sat_time(v);
      endcase
    endfunction

    function bit is_busy();
      return ph != PH_IDLE;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void go(phase_e p, time_t d);
      ph = p;
      left = d;
    endfunction

    function void start_slot();
      if (kind == OP_WRITE) go(PH_W_LOW, shift[0] ? cfg.write1_low : cfg.write0_low);
      else go(PH_R_LOW, cfg.read_low);
    endfunction

    // Performs what happens when the current phase runs out; 1 means the operation is done.
    function bit end_phase(logic line);
      case (ph)
        PH_SETTLE: begin
          if (kind == OP_RESET) go(PH_RST_LOW, cfg.reset_low);
          else start_slot();
        end
        PH_RST_LOW:  go(PH_RST_WAIT, cfg.pres_sample);
        PH_RST_WAIT: begin
          pres = !line;
          go(PH_RST_TAIL, cfg.reset_tail);
        end
        PH_W_LOW:    go(PH_W_HIGH, shift[0] ? HIGH_AFTER_ONE : HIGH_AFTER_ZERO);
        PH_R_LOW:    go(PH_R_WAIT, cfg.read_sample);
        PH_R_WAIT: begin
          shift = {line, shift[7:1]};
          go(PH_R_TAIL, READ_TAIL);
        end
        PH_W_HIGH, PH_R_TAIL: begin
          if (kind == OP_WRITE) shift = shift >> 1;
          if (bit_idx == 3'd7) begin
            if (kind == OP_READ) last_read = shift;
            go(PH_IDLE, '0);
            return 1'b1;
          end
          bit_idx = bit_idx + 3'd1;
          start_slot();
        end
        default: begin
          go(PH_IDLE, '0);
          return 1'b1;
        end
      endcase
      return 1'b0;
    endfunction

    function void note_item(op_e op, logic [7:0] data, logic line);
      bit active, done, rej;
      active = 1'b0;
      done = 1'b0;
      rej = 1'b0;
      items++;
      if (op == OP_TICK) begin
        if (ph != PH_IDLE) begin
          if (left != 0) left = left - 1'b1;
          active = 1'b1;
        end
      end else if (ph != PH_IDLE) begin
        rej = 1'b1;
        rejects++;
      end else begin
        kind = op;
        bit_idx = '0;
        shift = (op == OP_WRITE) ? data : 8'h00;
        go(PH_SETTLE, cfg.settle);
        active = 1'b1;
      end
      // Zero-length phases end on the same item, so keep going while time is used up.
      if (active) begin
        while (ph != PH_IDLE && left == 0) begin
          if (end_phase(line)) done = 1'b1;
        end
      end
      if (done) ops_done++;
      if (done && pres && kind == OP_RESET) presences++;
      expected_q.push_back({ph == PH_RST_LOW || ph == PH_W_LOW || ph == PH_R_LOW,
                            ph != PH_IDLE, done, pres, last_read, rej});
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= 30)
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task check_result(logic drv, logic busy, logic done, logic prs, logic [7:0] rd,
                      logic rej);
      logic [12:0] want;
      if (expected_q.size() == 0) begin
        report("unexpected result", {drv, busy, done, prs, rd, rej}, 0);
        return;
      end
      want = expected_q.pop_front();
      if (drv !== want[12]) report("drive_low", drv, want[12]);
      if (busy !== want[11]) report("busy_res", busy, want[11]);
      if (done !== want[10]) report("done_res", done, want[10]);
      if (prs !== want[9]) report("presence", prs, want[9]);
      if (rd !== want[8:1]) report("read_data", rd, want[8:1]);
      if (rej !== want[0]) report("rejected", rej, want[0]);
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i = OP_TICK;
  logic [7:0]           write_data_i = '0;
  logic                 line_level_i = 1'b1;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 drive_low_o;
  logic                 busy_res_o;
  logic                 done_res_o;
  logic                 presence_o;
  logic [7:0]           read_data_o;
  logic                 rejected_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  owb_scoreboard sb = new();
  int unsigned   burst_left = 0;
  int unsigned   cfg_phases = 0;

  one_wire_bus_master u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .write_data_i (write_data_i),
    .line_level_i (line_level_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .drive_low_o  (drive_low_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .presence_o   (presence_o),
    .read_data_o  (read_data_o),
    .rejected_o   (rejected_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout: results still outstanding");
    $display("CHECKS FAILED");
    $finish;
  end

  // The result side stalls in a mode picked at random: none, sparse, patterned or heavy.
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_cnt = 0;
  logic [15:0] stall_pat = '0;

  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_cnt = $urandom_range(50, 300);
      stall_pat = 16'($urandom);
    end
    stall_cnt--;
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    case (stall_mode)
      STALL_NONE:    out_stall_i = 1'b0;
      STALL_SPARSE:  out_stall_i = ($urandom_range(0, 3) == 0);
      STALL_PATTERN: out_stall_i = stall_pat[0];
      default:       out_stall_i = ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(drive_low_o, busy_res_o, done_res_o, presence_o, read_data_o,
                      rejected_o);
  end

  // Drives one item in bursts with random gaps and notes it once the block takes it.
  task automatic send_item(op_e op, logic [7:0] data, logic line);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    opcode_i = op;
    write_data_i = data;
    line_level_i = line;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, data, line);
  endtask

  // Ticks until the operation in flight is over, throwing in an occasional stray command.
  task automatic finish_op();
    while (sb.is_busy()) begin
      if ($urandom_range(0, 59) == 0)
        send_item(op_e'($urandom_range(OP_RESET, OP_READ)), 8'($urandom),
                  1'($urandom_range(0, 1)));
      else
        send_item(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_op(op_e op, logic [7:0] data);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    send_item(op, data, 1'($urandom_range(0, 1)));
    finish_op();
  endtask

  // Registers change only once every result is in; the callers leave the block idle first.
  task automatic load_cfg(cfg_val_t vals[8]);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_idx_i = cfg_idx_e'(i);
      cfg_wdata_i = vals[i];
      @(posedge clk_i);
      sb.set_reg(cfg_idx_e'(i), vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_phases++;
  endtask

  initial begin
    cfg_val_t vals[8];

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Timings straight out of reset.
    run_op(OP_WRITE, 8'hA5);

    // All register durations zero: a reset finishes on its own command item.
    foreach (vals[i]) vals[i] = '0;
    load_cfg(vals);
    send_item(OP_TICK, 8'h00, 1'b0);
    send_item(OP_TICK, 8'hFF, 1'b1);
    send_item(OP_RESET, 8'h00, 1'b0);
    send_item(OP_RESET, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h00, 1'b1);
    send_item(OP_RESET, 8'h00, 1'b0);
    send_item(OP_WRITE, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h55, 1'b0);
    finish_op();

    // Random operations under short random timings, a new setting for each operation.
    while (sb.items < 1100) begin
      foreach (vals[i])
        vals[i] = ($urandom_range(0, 7) == 0) ? cfg_val_t'($urandom_range(13, 120))
                                              : cfg_val_t'($urandom_range(0, 12));
      load_cfg(vals);
      run_op(op_e'($urandom_range(OP_RESET, OP_READ)), 8'($urandom));
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items over %0d register settings: %0d operations finished,",
             sb.items, cfg_phases, sb.ops_done);
    $display("%0d busy commands dropped and %0d resets answered by a device.",
             sb.rejects, sb.presences);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== one_wire_bus_master.f =====
+incdir+hw/rtl
hw/rtl/owb_pkg.sv
hw/rtl/one_wire_bus_master.sv
hw/rtl/owb_checker.sv
bench/testbench.sv
